/* rtl/sarp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarp_pkg
// shared types, widths and register indexes for the rolloff/pan pipeline
// ----------------------------------------------------------------------------
package sarp_pkg;

	localparam int PosW   = 24;
	localparam int FadeW  = 23;
	localparam int RightW = 16;
	localparam int DiffW  = 25;
	localparam int SqW    = 50;
	localparam int D2W    = 52;
	localparam int SW     = 32;
	localparam int DotW   = 42;
	localparam int R2W    = 48;
	localparam int CfgAw  = 3;
	localparam int CfgDw  = 24;
	localparam int GainW  = 17;
	localparam int PanQW  = 49;
	localparam int DefLatency = 3;
	localparam int DefSteps   = 4;

	localparam logic [CfgAw-1:0] REG_LISTENER_X = 3'd0;
	localparam logic [CfgAw-1:0] REG_LISTENER_Y = 3'd1;
	localparam logic [CfgAw-1:0] REG_LISTENER_Z = 3'd2;
	localparam logic [CfgAw-1:0] REG_RIGHT_X    = 3'd3;
	localparam logic [CfgAw-1:0] REG_RIGHT_Y    = 3'd4;
	localparam logic [CfgAw-1:0] REG_RIGHT_Z    = 3'd5;

	typedef struct packed {
		logic signed [PosW-1:0] src_x;
		logic signed [PosW-1:0] src_y;
		logic signed [PosW-1:0] src_z;
		logic [FadeW-1:0]       fade_distance;
	} in_word_t;

	typedef struct packed {
		logic [15:0]        gain;
		logic signed [15:0] pan;
	} out_word_t;

	typedef struct packed {
		logic signed [PosW-1:0]   lx;
		logic signed [PosW-1:0]   ly;
		logic signed [PosW-1:0]   lz;
		logic signed [RightW-1:0] rx;
		logic signed [RightW-1:0] ry;
		logic signed [RightW-1:0] rz;
	} cfg_t;

	// decision from front end: which gain region, zero distance, pan sign
	typedef struct packed {
		logic zero;
		logic near;
		logic far;
		logic neg;
	} cls_t;

endpackage

/* rtl/spatial_audio_rolloff_pan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_audio_rolloff_pan
// linear distance rolloff gain and stereo pan for one source per cycle
// ----------------------------------------------------------------------------
// usage: drive in_word and pulse start; a word is taken at every edge where
// start is high and busy is low. busy is never raised, so one source can be
// taken every cycle. each source gives one result word on result, marked by
// done for one cycle; the receiver cannot hold it off and must take it.
// the pipeline has 3 front stages (diff, products, sums), 8 square root
// stages, then 13 stages each for the two dividers running side by side,
// and one output register.
// throughput is one word per cycle, set by the fully pipelined sqrt and
// divider stages which each resolve up to four quotient or root bits.
// cfg_we/cfg_idx/cfg_data write listener position and right vector; the
// user must write them only while no source is in flight; not enforced.
// reset clears all valid bits; listener at origin facing right along +x.
// ----------------------------------------------------------------------------
module spatial_audio_rolloff_pan #(
	parameter int StepsPerStage = sarp_pkg::DefSteps
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  sarp_pkg::in_word_t               in_word,
	output logic                             done,
	output sarp_pkg::out_word_t              result,
	input  logic                             cfg_we,
	input  logic [sarp_pkg::CfgAw-1:0]       cfg_idx,
	input  logic [sarp_pkg::CfgDw-1:0]       cfg_data
);
	import sarp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lx <= '0;
			cfg_q.ly <= '0;
			cfg_q.lz <= '0;
			cfg_q.rx <= RightW'(16384);
			cfg_q.ry <= '0;
			cfg_q.rz <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LISTENER_X: cfg_q.lx <= cfg_data;
				REG_LISTENER_Y: cfg_q.ly <= cfg_data;
				REG_LISTENER_Z: cfg_q.lz <= cfg_data;
				REG_RIGHT_X:    cfg_q.rx <= cfg_data[RightW-1:0];
				REG_RIGHT_Y:    cfg_q.ry <= cfg_data[RightW-1:0];
				REG_RIGHT_Z:    cfg_q.rz <= cfg_data[RightW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic               f_vld;
	logic [D2W-1:0]     f_d2;
	logic [DotW-1:0]    f_mag;
	logic [FadeW-1:0]   f_r;
	cls_t               f_cls;

	sarp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_vld(start && !busy), .in_word(in_word),
		.cfg(cfg_q), .out_vld(f_vld), .d2(f_d2), .mag(f_mag), .fade(f_r), .cls(f_cls)
	);

	// side data through the root: cls, fade, magnitude
	localparam int SqSideW = $bits(cls_t) + FadeW + DotW;
	logic               q_vld;
	logic [SW-1:0]      q_s;
	logic [SqSideW-1:0] q_side;

	sarp_isqrt #(.StepsPerStage(StepsPerStage), .SideW(SqSideW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_vld(f_vld),
		.radicand({f_d2, 12'd0}), .side_in({f_cls, f_r, f_mag}),
		.out_vld(q_vld), .root(q_s), .side_out(q_side)
	);

	cls_t             q_cls;
	logic [FadeW-1:0] q_r;
	logic [DotW-1:0]  q_mag;
	assign {q_cls, q_r, q_mag} = q_side;

	// gain: floor(S*512/R), R forced nonzero when unused
	// numerator as wide as the pan divider so both have the same stage count
	localparam int GNumW = PanQW;
	logic [GNumW-1:0] g_quo;
	logic             g_vld;
	logic [$bits(cls_t)-1:0] g_side;

	sarp_div #(.NumW(GNumW), .DenW(FadeW), .StepsPerStage(StepsPerStage),
		.SideW($bits(cls_t))) u_gdiv (
		.clk(clk), .arst_n(arst_n), .in_vld(q_vld),
		.num(GNumW'({q_s, 9'd0})), .den((q_r == '0) ? FadeW'(1) : q_r),
		.side_in(q_cls), .out_vld(g_vld), .quo(g_quo), .side_out(g_side)
	);

	// pan: floor(mag*128/S), S forced nonzero for zero distance
	logic [PanQW-1:0] p_quo;
	logic             p_vld;
	logic             p_side;

	sarp_div #(.NumW(PanQW), .DenW(SW), .StepsPerStage(StepsPerStage),
		.SideW(1)) u_pdiv (
		.clk(clk), .arst_n(arst_n), .in_vld(q_vld),
		.num({q_mag, 7'd0}), .den((q_s == '0) ? SW'(1) : q_s),
		.side_in(1'b0), .out_vld(p_vld), .quo(p_quo), .side_out(p_side)
	);

	cls_t          o_cls;
	logic [15:0]   gain_c;
	logic [15:0]   pan_c;
	assign o_cls = g_side;

	always_comb begin
		if (o_cls.zero || o_cls.near) gain_c = 16'd32768;
		else if (o_cls.far) gain_c = '0;
		else if (g_quo >= GNumW'(65536)) gain_c = '0;
		else if (g_quo <= GNumW'(32768)) gain_c = 16'd32768;
		else gain_c = 16'(GNumW'(65536) - g_quo);
		if (o_cls.zero) pan_c = '0;
		else if (o_cls.neg) pan_c = (p_quo > PanQW'(32768)) ? 16'h8000 : 16'(-p_quo);
		else pan_c = (p_quo > PanQW'(32767)) ? 16'h7fff : 16'(p_quo);
	end

	logic      done_q;
	out_word_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= g_vld;
	end

	always_ff @(posedge clk) begin
		res_q.gain <= gain_c;
		res_q.pan  <= pan_c;
	end

	assign done   = done_q;
	assign result = res_q;

	div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		g_vld == p_vld)
		else $error("divider valids out of step");
	gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.gain <= 16'd32768)
		else $error("gain above unity");
	zero_pan: assert property (@(posedge clk) disable iff (!arst_n)
		g_vld && o_cls.zero && !p_side |=> result.pan == '0 && result.gain == 16'd32768)
		else $error("zero distance result wrong");
endmodule

/* rtl/sarp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarp_front
// difference, squares, dot products and the squared distance with its region
// ----------------------------------------------------------------------------
module sarp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_vld,
	input  sarp_pkg::in_word_t    in_word,
	input  sarp_pkg::cfg_t        cfg,
	output logic                  out_vld,
	output logic [sarp_pkg::D2W-1:0]  d2,
	output logic [sarp_pkg::DotW-1:0] mag,
	output logic [sarp_pkg::FadeW-1:0] fade,
	output sarp_pkg::cls_t        cls
);
	import sarp_pkg::*;

	logic signed [DiffW-1:0] dx_s1, dy_s1, dz_s1;
	logic [FadeW-1:0]        r_s1, r_s2, r_s3;
	logic                    v_s1, v_s2, v_s3;
	logic [SqW-1:0]          sx_s2, sy_s2, sz_s2;
	logic signed [DotW-1:0]  px_s2, py_s2, pz_s2;
	logic [R2W-1:0]          r2_s2;
	logic [D2W-1:0]          d2_s3;
	logic [DotW-1:0]         mag_s3;
	cls_t                    cls_s3;
	logic [D2W-1:0]          d2_c;
	logic signed [DotW-1:0]  dot_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DiffW'(in_word.src_x) - DiffW'(cfg.lx);
		dy_s1 <= DiffW'(in_word.src_y) - DiffW'(cfg.ly);
		dz_s1 <= DiffW'(in_word.src_z) - DiffW'(cfg.lz);
		r_s1  <= in_word.fade_distance;
	end

	// squares (signed, full width, nonnegative), dot terms, fade squared
	always_ff @(posedge clk) begin
		sx_s2 <= SqW'(dx_s1 * dx_s1);
		sy_s2 <= SqW'(dy_s1 * dy_s1);
		sz_s2 <= SqW'(dz_s1 * dz_s1);
		px_s2 <= DotW'(dx_s1 * cfg.rx);
		py_s2 <= DotW'(dy_s1 * cfg.ry);
		pz_s2 <= DotW'(dz_s1 * cfg.rz);
		r2_s2 <= R2W'(r_s1 * r_s1);
		r_s2  <= r_s1;
	end

	assign d2_c  = D2W'(sx_s2) + D2W'(sy_s2) + D2W'(sz_s2);
	assign dot_c = px_s2 + py_s2 + pz_s2;

	always_ff @(posedge clk) begin
		d2_s3       <= d2_c;
		mag_s3      <= dot_c[DotW-1] ? DotW'(-dot_c) : DotW'(dot_c);
		cls_s3.neg  <= dot_c[DotW-1];
		cls_s3.zero <= (d2_c == '0);
		cls_s3.near <= (d2_c <= D2W'(r2_s2));
		cls_s3.far  <= (d2_c >= {2'b00, r2_s2, 2'b00});
		r_s3        <= r_s2;
	end

	assign out_vld = v_s3;
	assign d2      = d2_s3;
	assign mag     = mag_s3;
	assign fade    = r_s3;
	assign cls     = cls_s3;

	cover_never_near_and_far: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cls_s3.near && !cls_s3.zero && r_s3 != '0 |-> !cls_s3.far)
		else $error("near and far both set");
	zero_is_near: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cls_s3.zero |-> cls_s3.near)
		else $error("zero distance not near");
	valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2)
		else $error("valid lost in front end");
endmodule

/* rtl/sarp_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarp_isqrt
// pipelined restoring square root, up to StepsPerStage result bits per stage
// ----------------------------------------------------------------------------
module sarp_isqrt #(
	parameter int StepsPerStage = 4,
	parameter int SideW = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_vld,
	input  logic [2*sarp_pkg::SW-1:0] radicand,
	input  logic [SideW-1:0]          side_in,
	output logic                      out_vld,
	output logic [sarp_pkg::SW-1:0]   root,
	output logic [SideW-1:0]          side_out
);
	import sarp_pkg::*;

	localparam int NStg = (SW + StepsPerStage - 1) / StepsPerStage;
	localparam int RemW = SW + 2;

	logic [2*SW-1:0] rad_q  [NStg+1];
	logic [RemW-1:0] rem_q  [NStg+1];
	logic [SW-1:0]   res_q  [NStg+1];
	logic [SideW-1:0] side_q [NStg+1];
	logic            vld_q  [NStg+1];

	assign rad_q[0]  = radicand;
	assign rem_q[0]  = '0;
	assign res_q[0]  = '0;
	assign side_q[0] = side_in;
	assign vld_q[0]  = in_vld;

	for (genvar g = 0; g < NStg; g++) begin : g_stg
		logic [2*SW-1:0] rad_c;
		logic [RemW-1:0] rem_c;
		logic [SW-1:0]   res_c;
		logic [RemW-1:0] trial;
		always_comb begin
			rad_c = rad_q[g];
			rem_c = rem_q[g];
			res_c = res_q[g];
			trial = '0;
			for (int k = 0; k < StepsPerStage; k++) begin
				if (g * StepsPerStage + k < SW) begin
					rem_c = {rem_c[RemW-3:0], rad_c[2*SW-1 -: 2]};
					rad_c = {rad_c[2*SW-3:0], 2'b00};
					trial = {res_c, 2'b01};
					if (rem_c >= trial) begin
						rem_c = rem_c - trial;
						res_c = {res_c[SW-2:0], 1'b1};
					end else begin
						res_c = {res_c[SW-2:0], 1'b0};
					end
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[g+1] <= 1'b0;
			else vld_q[g+1] <= vld_q[g];
		end
		always_ff @(posedge clk) begin
			rad_q[g+1]  <= rad_c;
			rem_q[g+1]  <= rem_c;
			res_q[g+1]  <= res_c;
			side_q[g+1] <= side_q[g];
		end
	end

	assign out_vld  = vld_q[NStg];
	assign root     = res_q[NStg];
	assign side_out = side_q[NStg];
endmodule

/* rtl/sarp_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sarp_div
// pipelined unsigned restoring divider, up to StepsPerStage quotient bits per stage
// ----------------------------------------------------------------------------
module sarp_div #(
	parameter int NumW = 32,
	parameter int DenW = 32,
	parameter int StepsPerStage = 4,
	parameter int SideW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_vld,
	input  logic [NumW-1:0]  num,
	input  logic [DenW-1:0]  den,
	input  logic [SideW-1:0] side_in,
	output logic             out_vld,
	output logic [NumW-1:0]  quo,
	output logic [SideW-1:0] side_out
);
	localparam int NStg = (NumW + StepsPerStage - 1) / StepsPerStage;
	localparam int RemW = DenW + 1;

	logic [NumW-1:0]  num_q  [NStg+1];
	logic [DenW-1:0]  den_q  [NStg+1];
	logic [RemW-1:0]  rem_q  [NStg+1];
	logic [SideW-1:0] side_q [NStg+1];
	logic             vld_q  [NStg+1];

	assign num_q[0]  = num;
	assign den_q[0]  = den;
	assign rem_q[0]  = '0;
	assign side_q[0] = side_in;
	assign vld_q[0]  = in_vld;

	// numerator register shifts quotient bits in from the bottom
	for (genvar g = 0; g < NStg; g++) begin : g_stg
		logic [NumW-1:0] num_c;
		logic [RemW-1:0] rem_c;
		logic            qb;
		always_comb begin
			num_c = num_q[g];
			rem_c = rem_q[g];
			qb    = 1'b0;
			for (int k = 0; k < StepsPerStage; k++) begin
				if (g * StepsPerStage + k < NumW) begin
					rem_c = {rem_c[RemW-2:0], num_c[NumW-1]};
					qb    = (rem_c >= RemW'(den_q[g]));
					if (qb) rem_c = rem_c - RemW'(den_q[g]);
					num_c = {num_c[NumW-2:0], qb};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_q[g+1] <= 1'b0;
			else vld_q[g+1] <= vld_q[g];
		end
		always_ff @(posedge clk) begin
			num_q[g+1]  <= num_c;
			den_q[g+1]  <= den_q[g];
			rem_q[g+1]  <= rem_c;
			side_q[g+1] <= side_q[g];
		end
	end

	assign out_vld  = vld_q[NStg];
	assign quo      = num_q[NStg];
	assign side_out = side_q[NStg];
endmodule
